@@ sv/nfta_pkg.sv @@
// Shared constants for the next-fit ticket allocator: field widths,
// request and status codes, and the bitmap word geometry.
// No dependencies; compiled first.
package nfta_pkg;

    localparam int NUM_TICKETS_DEF = 1024;
    localparam int TICKET_W        = 10;
    localparam int STATUS_W        = 2;

    // The in-use bitmap is stored as words of this many tickets.
    localparam int WORD_W = 32;
    localparam int OFS_W  = $clog2(WORD_W);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREED    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd3;

endpackage

@@ sv/nfta_req_if.sv @@
// Request channel of the ticket allocator: valid/ready handshake with
// the request kind and the ticket to free. Depends on nfta_pkg.
interface nfta_req_if;

    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [nfta_pkg::TICKET_W-1:0] ticket_in;

    modport source (output valid, output op, output ticket_in, input ready);
    modport sink   (input valid, input op, input ticket_in, output ready);

endinterface

@@ sv/nfta_rsp_if.sv @@
// Result channel of the ticket allocator: valid/ready handshake with
// the ticket number and the status code. Depends on nfta_pkg.
interface nfta_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [nfta_pkg::TICKET_W-1:0] ticket_out;
    logic [nfta_pkg::STATUS_W-1:0] status;

    modport source (output valid, output ticket_out, output status, input ready);
    modport sink   (input valid, input ticket_out, input status, output ready);

endinterface

@@ sv/nfta_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module nfta_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                   wr_data,
    input  logic                                rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                   rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/next_fit_ticket_allocator_core.sv @@
// Next-fit ticket allocator core: a word-organized in-use bitmap held in
// one RAM, scanned by a read-modify-write sequencer.
// Depends on nfta_pkg, nfta_req_if, nfta_rsp_if and nfta_ram.
//
// Requests arrive on req (valid/ready). op = allocate hands out the first free
// ticket at or after the seek position, wrapping to zero; op = free returns
// ticket_in to the pool. Each request yields exactly one result on rsp:
// granted, pool full, freed, or free of an unissued ticket.
// The bitmap is stored as NUM_TICKETS/32 words (rounded up), and one request
// is in flight at a time. A free passes through a check-and-write state,
// then a result state that loads the result register; an out-of-range
// ticket goes straight to the result state. An allocate reads one word per
// cycle until it finds a free ticket; when the pool is full it reads every
// word once, then the first word again for the bits below the seek position.
// The next request is taken once the result register is loaded and the
// block is back in idle. After reset a clearing pass writes zero to every
// bitmap word, one per cycle; req.ready stays low until it is done. A waiting
// result does not block a new request; the block only holds when a finished
// result finds the result register still occupied.
module next_fit_ticket_allocator_core #(
    parameter int NUM_TICKETS = nfta_pkg::NUM_TICKETS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    nfta_req_if.sink   req,
    nfta_rsp_if.source rsp
);

    localparam int WORD_W  = nfta_pkg::WORD_W;
    localparam int OFS_W   = nfta_pkg::OFS_W;
    localparam int WORDS   = (NUM_TICKETS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PAD_W   = WADDR_W + OFS_W;
    localparam int TIDX_W  = $clog2(NUM_TICKETS);
    localparam int PASS_W  = $clog2(WORDS + 1);
    localparam int TAIL    = NUM_TICKETS % WORD_W;

    localparam logic [WADDR_W-1:0] LAST_WORD  = WADDR_W'(WORDS - 1);
    localparam logic [PASS_W-1:0]  LAST_PASS  = PASS_W'(WORDS);
    // Bits of the top word that lie beyond the pool count as taken.
    localparam logic [WORD_W-1:0]  TAIL_MASK  =
        (TAIL == 0) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << TAIL) - 64'd1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    // Lowest set bit of a bitmap word.
    function automatic logic [OFS_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [OFS_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = OFS_W'(i);
            end
        end
        return r;
    endfunction

    state_t                          state_reg, state_next;
    logic [WADDR_W-1:0]              word_reg, word_next;
    logic [PASS_W-1:0]               pass_reg, pass_next;
    logic [TIDX_W-1:0]               seek_reg, seek_next;
    logic                            op_reg, op_next;
    logic [nfta_pkg::TICKET_W-1:0]   tick_reg, tick_next;
    logic [nfta_pkg::TICKET_W-1:0]   res_ticket_reg, res_ticket_next;
    logic [nfta_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                            out_valid_reg, out_valid_next;
    logic [nfta_pkg::TICKET_W-1:0]   out_ticket_reg, out_ticket_next;
    logic [nfta_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;

    logic                  ram_wr_en;
    logic [WADDR_W-1:0]    ram_wr_addr;
    logic [WORD_W-1:0]     ram_wr_data;
    logic                  ram_rd_en;
    logic [WADDR_W-1:0]    ram_rd_addr;
    logic [WORD_W-1:0]     ram_rd_data;

    nfta_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (WORDS)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Seek position and incoming ticket split into word and bit offset.
    logic [PAD_W-1:0]   seek_pad;
    logic [WADDR_W-1:0] seek_word;
    logic [OFS_W-1:0]   seek_ofs;
    logic [PAD_W-1:0]   tin_pad;
    logic               tin_in_range;

    assign seek_pad     = PAD_W'(seek_reg);
    assign seek_word    = seek_pad[PAD_W-1:OFS_W];
    assign seek_ofs     = seek_pad[OFS_W-1:0];
    assign tin_pad      = PAD_W'(32'(req.ticket_in));
    assign tin_in_range = 32'(req.ticket_in) < 32'(NUM_TICKETS);

    // Candidate free bits of the word just read. The first pass skips bits
    // below the seek position; the closing pass over the same word sees
    // only those bits.
    logic [WORD_W-1:0]  below_seek;
    logic [WORD_W-1:0]  free_vec;
    logic               any_free;
    logic [OFS_W-1:0]   free_ofs;
    logic [PAD_W-1:0]   found;
    logic [31:0]        found_plus1;

    always_comb
    begin
        below_seek = (WORD_W'(1) << seek_ofs) - WORD_W'(1);
        free_vec   = ~ram_rd_data;
        if (word_reg == LAST_WORD)
        begin
            free_vec = free_vec & TAIL_MASK;
        end
        if (pass_reg == '0)
        begin
            free_vec = free_vec & ~below_seek;
        end
        if (pass_reg == LAST_PASS)
        begin
            free_vec = free_vec & below_seek;
        end
        any_free    = |free_vec;
        free_ofs    = lowest_set(free_vec);
        found       = {word_reg, free_ofs};
        found_plus1 = 32'(found) + 32'd1;
    end

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        pass_next       = pass_reg;
        seek_next       = seek_reg;
        op_next         = op_reg;
        tick_next       = tick_reg;
        res_ticket_next = res_ticket_reg;
        res_status_next = res_status_reg;
        out_ticket_next = out_ticket_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        ram_wr_en   = 1'b0;
        ram_wr_addr = word_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = word_reg;
        req.ready   = (state_reg == S_IDLE);

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en = 1'b1;
                if (word_reg == LAST_WORD)
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + WADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.op;
                    tick_next = req.ticket_in;
                    pass_next = '0;
                    if (req.op == nfta_pkg::OP_ALLOC)
                    begin
                        word_next   = seek_word;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = seek_word;
                        state_next  = S_SCAN;
                    end
                    else if (tin_in_range)
                    begin
                        word_next   = tin_pad[PAD_W-1:OFS_W];
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = tin_pad[PAD_W-1:OFS_W];
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        res_ticket_next = req.ticket_in;
                        res_status_next = nfta_pkg::STATUS_BAD_FREE;
                        state_next      = S_RESP;
                    end
                end
            end

            S_SCAN:
            begin
                if (op_reg == nfta_pkg::OP_FREE)
                begin
                    res_ticket_next = tick_reg;
                    if (ram_rd_data[tick_reg[OFS_W-1:0]])
                    begin
                        ram_wr_en       = 1'b1;
                        ram_wr_data     = ram_rd_data
                                          & ~(WORD_W'(1) << tick_reg[OFS_W-1:0]);
                        res_status_next = nfta_pkg::STATUS_FREED;
                    end
                    else
                    begin
                        res_status_next = nfta_pkg::STATUS_BAD_FREE;
                    end
                    state_next = S_RESP;
                end
                else if (any_free)
                begin
                    ram_wr_en       = 1'b1;
                    ram_wr_data     = ram_rd_data | (WORD_W'(1) << free_ofs);
                    res_ticket_next = nfta_pkg::TICKET_W'(found);
                    res_status_next = nfta_pkg::STATUS_GRANTED;
                    if (found_plus1 >= 32'(NUM_TICKETS))
                    begin
                        seek_next = '0;
                    end
                    else
                    begin
                        seek_next = TIDX_W'(found_plus1);
                    end
                    state_next = S_RESP;
                end
                else if (pass_reg == LAST_PASS)
                begin
                    res_ticket_next = '0;
                    res_status_next = nfta_pkg::STATUS_FULL;
                    seek_next       = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    // Move on to the next word, wrapping past the top.
                    if (word_reg == LAST_WORD)
                    begin
                        word_next = '0;
                    end
                    else
                    begin
                        word_next = word_reg + WADDR_W'(1);
                    end
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = word_next;
                    pass_next   = pass_reg + PASS_W'(1);
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_ticket_next = res_ticket_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            word_reg       <= '0;
            pass_reg       <= '0;
            seek_reg       <= '0;
            op_reg         <= nfta_pkg::OP_ALLOC;
            tick_reg       <= '0;
            res_ticket_reg <= '0;
            res_status_reg <= nfta_pkg::STATUS_GRANTED;
            out_valid_reg  <= 1'b0;
            out_ticket_reg <= '0;
            out_status_reg <= nfta_pkg::STATUS_GRANTED;
        end
        else
        begin
            state_reg      <= state_next;
            word_reg       <= word_next;
            pass_reg       <= pass_next;
            seek_reg       <= seek_next;
            op_reg         <= op_next;
            tick_reg       <= tick_next;
            res_ticket_reg <= res_ticket_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_ticket_reg <= out_ticket_next;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ticket_out = out_ticket_reg;
    assign rsp.status     = out_status_reg;

endmodule
